// ===== sv/pcol_pkg.sv =====
// Package for the particle pair collision block.
// Widths, stage counts, register codes and the saturation helper.
// No dependencies.
package pcol_pkg;

    localparam int POS_W      = 24;
    localparam int TAG_W      = 16;
    localparam int RAD_W      = 8;
    localparam int FRAC_BITS  = 10;
    localparam int DIFF_W     = POS_W + 1;
    // Minimum distance is 2*radius pixels, below 2**MAG_W position units
    localparam int MAG_W      = RAD_W + FRAC_BITS + 1;
    localparam int SQR_W      = 2 * MAG_W;
    localparam int D2_W       = SQR_W + 1;
    localparam int ROOT_W     = MAG_W;
    localparam int REM_W      = D2_W + 1;
    localparam int OV3_W      = MAG_W + 2;
    localparam int NUM_W      = MAG_W + OV3_W;
    localparam int DEN_W      = ROOT_W + 4;
    localparam int Q_W        = MAG_W - 1;
    localparam int DREM_W     = NUM_W + 1;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int DIV_STAGES = Q_W;
    localparam int SUM_W      = POS_W + 2;

    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_RADIUS = 1'b0;
    localparam logic [RAD_W-1:0] RADIUS_RESET = 8'd5;

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(8388608);

    // Sideband that travels beside the arithmetic
    typedef struct packed {
        logic [TAG_W-1:0]        tag_a;
        logic [TAG_W-1:0]        tag_b;
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic                    neg_x;
        logic                    neg_y;
        logic [MAG_W-1:0]        mag_x;
        logic [MAG_W-1:0]        mag_y;
        logic [MAG_W-1:0]        md;
        logic                    hit;
    } t_sb;

    // Clamp a widened coordinate into the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > POS_MAX) c = POS_MAX;
        if (v < POS_MIN) c = POS_MIN;
        return c[POS_W-1:0];
    endfunction

endpackage

// ===== sv/pcol_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on pcol_pkg.
module pcol_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [pcol_pkg::D2_W-1:0]    i_rad,
    output logic [pcol_pkg::ROOT_W-1:0]  o_root
);

    logic [pcol_pkg::REM_W-1:0]  r_rem  [0:pcol_pkg::SQ_STAGES-1];
    logic [pcol_pkg::ROOT_W-1:0] r_root [0:pcol_pkg::SQ_STAGES-1];

    for (genvar g = 0; g < pcol_pkg::SQ_STAGES; g++) begin : g_stage
        localparam int BI = pcol_pkg::ROOT_W - 1 - g;
        logic [pcol_pkg::REM_W-1:0]  rem_in;
        logic [pcol_pkg::ROOT_W-1:0] root_in;
        logic [pcol_pkg::REM_W-1:0]  trial;
        logic [pcol_pkg::REM_W-1:0]  n_rem;
        logic [pcol_pkg::ROOT_W-1:0] n_root;

        // First stage takes the radicand, later ones the previous stage
        if (g == 0) begin : g_head
            assign rem_in  = pcol_pkg::REM_W'(i_rad);
            assign root_in = '0;
        end else begin : g_tail
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        // Try setting bit BI: (r + 2^BI)^2 - r^2 = r*2^(BI+1) + 4^BI
        always_comb begin
            trial = (pcol_pkg::REM_W'(root_in) << (BI + 1))
                  + (pcol_pkg::REM_W'(1) << (2 * BI));
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = root_in | (pcol_pkg::ROOT_W'(1) << BI);
            end else begin
                n_rem  = rem_in;
                n_root = root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_root = r_root[pcol_pkg::SQ_STAGES-1];

endmodule

// ===== sv/pcol_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pcol_pkg.
module pcol_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [pcol_pkg::NUM_W-1:0]  i_num,
    input  logic [pcol_pkg::DEN_W-1:0]  i_den,
    output logic [pcol_pkg::Q_W-1:0]    o_q
);

    logic [pcol_pkg::DREM_W-1:0] r_rem [0:pcol_pkg::DIV_STAGES-1];
    logic [pcol_pkg::DEN_W-1:0]  r_den [0:pcol_pkg::DIV_STAGES-1];
    logic [pcol_pkg::Q_W-1:0]    r_q   [0:pcol_pkg::DIV_STAGES-1];

    for (genvar g = 0; g < pcol_pkg::DIV_STAGES; g++) begin : g_stage
        localparam int BI = pcol_pkg::Q_W - 1 - g;
        logic [pcol_pkg::DREM_W-1:0] rem_in;
        logic [pcol_pkg::DEN_W-1:0]  den_in;
        logic [pcol_pkg::Q_W-1:0]    q_in;
        logic [pcol_pkg::DREM_W-1:0] sub;
        logic [pcol_pkg::DREM_W-1:0] n_rem;
        logic [pcol_pkg::Q_W-1:0]    n_q;

        // First stage takes the operands, later ones the previous stage
        if (g == 0) begin : g_head
            assign rem_in = pcol_pkg::DREM_W'(i_num);
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_tail
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign q_in   = r_q[g-1];
        end

        // Subtract the shifted divisor where it fits
        always_comb begin
            sub = pcol_pkg::DREM_W'(den_in) << BI;
            if (rem_in >= sub) begin
                n_rem = rem_in - sub;
                n_q   = q_in | (pcol_pkg::Q_W'(1) << BI);
            end else begin
                n_rem = rem_in;
                n_q   = q_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_den[g] <= den_in;
                r_q[g]   <= n_q;
            end
        end
    end

    assign o_q = r_q[pcol_pkg::DIV_STAGES-1];

endmodule

// ===== sv/particle_pair_collision.sv =====
// Pipeline of 43 register stages: 3 front, 19-stage root, 2 overlap stages,
// 18-stage divider, output register.
// Throughput: one item per cycle; the whole pipeline holds while the output item waits.
// Reset (synchronous, active low) clears all valid bits and sets radius to 5.
// Uses pcol_pkg, pcol_sqrt and pcol_div.
module particle_pair_collision (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pcol_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [pcol_pkg::TAG_W-1:0]         i_tag_a,
    input  logic [pcol_pkg::TAG_W-1:0]         i_tag_b,
    input  logic signed [pcol_pkg::POS_W-1:0]  i_a_x,
    input  logic signed [pcol_pkg::POS_W-1:0]  i_a_y,
    input  logic signed [pcol_pkg::POS_W-1:0]  i_b_x,
    input  logic signed [pcol_pkg::POS_W-1:0]  i_b_y,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [pcol_pkg::TAG_W-1:0]         o_out_tag_a,
    output logic [pcol_pkg::TAG_W-1:0]         o_out_tag_b,
    output logic signed [pcol_pkg::POS_W-1:0]  o_new_a_x,
    output logic signed [pcol_pkg::POS_W-1:0]  o_new_a_y,
    output logic signed [pcol_pkg::POS_W-1:0]  o_new_b_x,
    output logic signed [pcol_pkg::POS_W-1:0]  o_new_b_y,
    output logic                               o_moved
);

    localparam int SQL = pcol_pkg::SQ_STAGES;
    localparam int DVL = pcol_pkg::DIV_STAGES;

    logic en;
    logic wr_radius;
    logic [pcol_pkg::RAD_W-1:0] r_radius;

    // Pipeline advances unless the output item is stalled
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign pready     = 1'b1;

    // Configuration register
    assign wr_radius = psel && penable && pwrite && (paddr[2] == pcol_pkg::REG_RADIUS);
    assign prdata    = (paddr[2] == pcol_pkg::REG_RADIUS) ? 32'(r_radius) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= pcol_pkg::RADIUS_RESET;
        end else if (wr_radius) begin
            r_radius <= pwdata[pcol_pkg::RAD_W-1:0];
        end
    end

    // Stage A: capture, differences
    logic r_a_vld;
    pcol_pkg::t_sb r_a_sb;
    logic signed [pcol_pkg::DIFF_W-1:0] r_a_dx, r_a_dy;
    pcol_pkg::t_sb n_a_sb;

    always_comb begin
        n_a_sb       = '0;
        n_a_sb.tag_a = i_tag_a;
        n_a_sb.tag_b = i_tag_b;
        n_a_sb.a_x   = i_a_x;
        n_a_sb.a_y   = i_a_y;
        n_a_sb.b_x   = i_b_x;
        n_a_sb.b_y   = i_b_y;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sb <= n_a_sb;
            r_a_dx <= pcol_pkg::DIFF_W'(i_a_x) - pcol_pkg::DIFF_W'(i_b_x);
            r_a_dy <= pcol_pkg::DIFF_W'(i_a_y) - pcol_pkg::DIFF_W'(i_b_y);
        end
    end

    // Stage B: magnitudes, squares, squared minimum distance
    logic r_b_vld;
    pcol_pkg::t_sb r_b_sb;
    logic [pcol_pkg::SQR_W-1:0] r_b_sq_x, r_b_sq_y, r_b_md2;
    logic r_b_small;
    logic [pcol_pkg::DIFF_W-1:0] abs_x, abs_y;
    pcol_pkg::t_sb n_b_sb;

    always_comb begin
        abs_x = r_a_dx[pcol_pkg::DIFF_W-1] ? pcol_pkg::DIFF_W'(-r_a_dx)
                                           : pcol_pkg::DIFF_W'(r_a_dx);
        abs_y = r_a_dy[pcol_pkg::DIFF_W-1] ? pcol_pkg::DIFF_W'(-r_a_dy)
                                           : pcol_pkg::DIFF_W'(r_a_dy);
        n_b_sb       = r_a_sb;
        n_b_sb.neg_x = r_a_dx[pcol_pkg::DIFF_W-1];
        n_b_sb.neg_y = r_a_dy[pcol_pkg::DIFF_W-1];
        n_b_sb.mag_x = abs_x[pcol_pkg::MAG_W-1:0];
        n_b_sb.mag_y = abs_y[pcol_pkg::MAG_W-1:0];
        n_b_sb.md    = pcol_pkg::MAG_W'(r_radius) << (pcol_pkg::FRAC_BITS + 1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sb    <= n_b_sb;
            r_b_sq_x  <= n_b_sb.mag_x * n_b_sb.mag_x;
            r_b_sq_y  <= n_b_sb.mag_y * n_b_sb.mag_y;
            r_b_md2   <= n_b_sb.md * n_b_sb.md;
            // a larger axis difference is beyond any minimum distance
            r_b_small <= (abs_x[pcol_pkg::DIFF_W-1:pcol_pkg::MAG_W] == '0)
                      && (abs_y[pcol_pkg::DIFF_W-1:pcol_pkg::MAG_W] == '0);
        end
    end

    // Stage C: squared distance and overlap test
    logic r_c_vld;
    pcol_pkg::t_sb r_c_sb;
    logic [pcol_pkg::D2_W-1:0] r_c_d2;
    logic [pcol_pkg::D2_W-1:0] d2;
    pcol_pkg::t_sb n_c_sb;

    always_comb begin
        d2         = pcol_pkg::D2_W'(r_b_sq_x) + pcol_pkg::D2_W'(r_b_sq_y);
        n_c_sb     = r_b_sb;
        n_c_sb.hit = r_b_small && (d2 != '0) && (d2 < pcol_pkg::D2_W'(r_b_md2));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_sb <= n_c_sb;
            r_c_d2 <= d2;
        end
    end

    // Square root of the squared distance
    logic [pcol_pkg::ROOT_W-1:0] root;

    pcol_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_c_d2),
        .o_root (root)
    );

    logic          r_s_vld [0:SQL-1];
    pcol_pkg::t_sb r_s_sb  [0:SQL-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_sb[0] <= r_c_sb;
            for (int k = 1; k < SQL; k++) begin
                r_s_sb[k] <= r_s_sb[k-1];
            end
        end
    end

    // Stage D: three times the overlap
    logic r_d_vld;
    pcol_pkg::t_sb r_d_sb;
    logic [pcol_pkg::OV3_W-1:0]  r_d_ov3;
    logic [pcol_pkg::ROOT_W-1:0] r_d_dist;
    logic [pcol_pkg::MAG_W-1:0]  ov;

    assign ov = r_s_sb[SQL-1].md - root;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sb   <= r_s_sb[SQL-1];
            r_d_ov3  <= (pcol_pkg::OV3_W'(ov) << 1) + pcol_pkg::OV3_W'(ov);
            r_d_dist <= root;
        end
    end

    // Stage E: numerators and divisor
    logic r_e_vld;
    logic [pcol_pkg::NUM_W-1:0] r_e_num_x, r_e_num_y;
    logic [pcol_pkg::DEN_W-1:0] r_e_den;
    pcol_pkg::t_sb r_e_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_sb    <= r_d_sb;
            r_e_num_x <= r_d_sb.mag_x * r_d_ov3;
            r_e_num_y <= r_d_sb.mag_y * r_d_ov3;
            r_e_den   <= {r_d_dist, 4'b0000};
        end
    end

    // Shift magnitudes per axis
    logic [pcol_pkg::Q_W-1:0] q_x, q_y;

    pcol_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_e_num_x),
        .i_den (r_e_den),
        .o_q   (q_x)
    );

    pcol_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_e_num_y),
        .i_den (r_e_den),
        .o_q   (q_y)
    );

    logic          r_v_vld [0:DVL-1];
    pcol_pkg::t_sb r_v_sb  [0:DVL-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v_sb[0] <= r_e_sb;
            for (int k = 1; k < DVL; k++) begin
                r_v_sb[k] <= r_v_sb[k-1];
            end
        end
    end

    // Output stage: apply signed shifts and saturate
    pcol_pkg::t_sb o_sb;
    logic signed [pcol_pkg::SUM_W-1:0] s_x, s_y;

    assign o_sb = r_v_sb[DVL-1];

    always_comb begin
        s_x = $signed(pcol_pkg::SUM_W'(q_x));
        s_y = $signed(pcol_pkg::SUM_W'(q_y));
        if (o_sb.neg_x) s_x = -s_x;
        if (o_sb.neg_y) s_y = -s_y;
        if (!o_sb.hit) begin
            s_x = '0;
            s_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_tag_a <= o_sb.tag_a;
            o_out_tag_b <= o_sb.tag_b;
            o_new_a_x   <= pcol_pkg::sat_pos(pcol_pkg::SUM_W'(o_sb.a_x) + s_x);
            o_new_a_y   <= pcol_pkg::sat_pos(pcol_pkg::SUM_W'(o_sb.a_y) + s_y);
            o_new_b_x   <= pcol_pkg::sat_pos(pcol_pkg::SUM_W'(o_sb.b_x) - s_x);
            o_new_b_y   <= pcol_pkg::sat_pos(pcol_pkg::SUM_W'(o_sb.b_y) - s_y);
            o_moved     <= o_sb.hit;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            r_d_vld     <= 1'b0;
            r_e_vld     <= 1'b0;
            o_out_valid <= 1'b0;
            for (int k = 0; k < SQL; k++) begin
                r_s_vld[k] <= 1'b0;
            end
            for (int k = 0; k < DVL; k++) begin
                r_v_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_a_vld    <= i_in_valid;
            r_b_vld    <= r_a_vld;
            r_c_vld    <= r_b_vld;
            r_s_vld[0] <= r_c_vld;
            for (int k = 1; k < SQL; k++) begin
                r_s_vld[k] <= r_s_vld[k-1];
            end
            r_d_vld    <= r_s_vld[SQL-1];
            r_e_vld    <= r_d_vld;
            r_v_vld[0] <= r_e_vld;
            for (int k = 1; k < DVL; k++) begin
                r_v_vld[k] <= r_v_vld[k-1];
            end
            o_out_valid <= r_v_vld[DVL-1];
        end
    end

    // Overlap is at least one unit whenever a response applies
    a_root_below_md: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_vld[SQL-1] && r_s_sb[SQL-1].hit) |-> (root < r_s_sb[SQL-1].md))
        else $error("root not below minimum distance on a hit");

    // Divisor is nonzero for every item that gets a response
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && r_e_sb.hit) |-> (r_e_den != '0))
        else $error("zero divisor on a hit");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
